// ===== rtl/dlsc_pkg.sv =====
// dlsc_pkg: shared types, time constants and segment helpers for the daylight schedule curve
// no dependencies; imported by dlsc_blend8, daylight_led_schedule_curve and the testbench
package dlsc_pkg;

  localparam int unsigned SEC_W  = 17;
  localparam int unsigned MIN_W  = 12;
  localparam int unsigned ELAP_W = 15;

  localparam logic [SEC_W-1:0] SEC_05 = 17'd18000;
  localparam logic [SEC_W-1:0] SEC_08 = 17'd28800;
  localparam logic [SEC_W-1:0] SEC_16 = 17'd57600;
  localparam logic [SEC_W-1:0] SEC_21 = 17'd75600;
  localparam logic [SEC_W-1:0] SEC_22 = 17'd79200;

  localparam logic [MIN_W-1:0] MIN_22         = 12'd1320;
  localparam logic [MIN_W-1:0] MIN_WRAP       = 12'd120;
  localparam logic [MIN_W-1:0] NIGHT_SPAN_MIN = 12'd360;

  // floor(s / 60) = (s * 139811) >> 23, exact for every 17-bit s
  localparam int unsigned      DIV60_W     = 18;
  localparam logic [DIV60_W-1:0] DIV60_MUL = 18'd139811;
  localparam int unsigned      DIV60_SHIFT = 23;

  localparam logic [ELAP_W-1:0] LEN_RISE  = 15'd10800;
  localparam logic [ELAP_W-1:0] LEN_FADE  = 15'd18000;
  localparam logic [ELAP_W-1:0] LEN_DUSK  = 15'd3600;
  localparam logic [ELAP_W-1:0] LEN_NIGHT = 15'd360;

  // fraction = (e * ceil(2^(F+sh) / len)) >> sh; 2^sh exceeds len * (len - 1),
  // which keeps the result exact for every e below len
  localparam int unsigned RCP_SH_RISE  = 27;
  localparam int unsigned RCP_SH_FADE  = 29;
  localparam int unsigned RCP_SH_DUSK  = 24;
  localparam int unsigned RCP_SH_NIGHT = 17;
  localparam int unsigned RCP_HEAD_W   = 15;  // reciprocal bits above F

  localparam logic [7:0] FALLBACK_LEVEL = 8'd200;

  typedef enum logic [2:0] {
    SEG_FALLBACK,
    SEG_RISE,
    SEG_DAY,
    SEG_FADE,
    SEG_DUSK,
    SEG_NIGHT,
    SEG_HOLD
  } seg_e;

  typedef enum logic [2:0] {
    CFG_NIGHT_LEVEL   = 3'd0,
    CFG_PEAK_LEVEL    = 3'd1,
    CFG_EVENING_LEVEL = 3'd2,
    CFG_MORNING_RGB   = 3'd3,
    CFG_DAY_RGB       = 3'd4,
    CFG_EVENING_RGB   = 3'd5,
    CFG_NIGHT_RGB     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic prod;
    logic out;
  } lane_en_t;

  // segment length of each span; constant segments carry zero elapsed time
  function automatic logic [ELAP_W-1:0] seg_len(seg_e seg);
    logic [ELAP_W-1:0] len;
    unique case (seg)
      SEG_RISE:  len = LEN_RISE;
      SEG_FADE:  len = LEN_FADE;
      SEG_DUSK:  len = LEN_DUSK;
      default:   len = LEN_NIGHT;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/dlsc_blend8.sv =====
// dlsc_blend8: two-stage rounded linear blend of two 8-bit values by a Q0.F fraction
// depends on dlsc_pkg (lane_en_t)
module dlsc_blend8
  import dlsc_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  lane_en_t                 en_i,
  input  logic [7:0]               a_i,
  input  logic [7:0]               b_i,
  input  logic [FRACTION_BITS-1:0] t_i,
  output logic [7:0]               y_o
);

  localparam int unsigned ACC_W = FRACTION_BITS + 10;
  localparam logic [ACC_W-1:0] HALF =
    {{(ACC_W - FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS - 1){1'b0}}};

  logic signed [8:0]       diff;
  logic signed [ACC_W-1:0] prod_d, prod_q;
  logic [7:0]              a_q;
  logic [ACC_W-1:0]        acc;
  logic [7:0]              y_q;

  assign diff   = $signed({1'b0, b_i}) - $signed({1'b0, a_i});
  assign prod_d = diff * $signed({1'b0, t_i});

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      a_q    <= a_i;
      prod_q <= prod_d;
    end
  end

  // result lies between the endpoints, so the sum never leaves 0..255
  assign acc = {2'b00, a_q, {FRACTION_BITS{1'b0}}} + $unsigned(prod_q) + HALF;

  always_ff @(posedge clk_i) begin
    if (en_i.out) begin
      y_q <= acc[FRACTION_BITS +: 8];
    end
  end

  assign y_o = y_q;

endmodule

// ===== rtl/daylight_led_schedule_curve.sv =====
// daylight_led_schedule_curve: time of day to LED brightness and color along a daily curve
// depends on dlsc_pkg and dlsc_blend8 (four lanes: brightness, red, green, blue)
//
//   channel  signals                                        direction
//   cfg      cfg_we_i cfg_index_i cfg_data_i                 in, write only, no wait
//   in       in_valid_i in_ready_o time_valid_i second_of_day_i   in
//   out      out_valid_o out_ready_i brightness_o color_rgb_o     out
//
// one transfer per cycle sustained while out_ready_i is high; five register stages
// stages: classify and minute count, elapsed time, reciprocal-multiply fraction,
// blend multiply, round
// each stage has its own valid bit and loads when empty or when the next stage moves,
// so bubbles close up and a stalled output still lets the front take transfers until all stages are full
// reset clears the valid bits and loads the register defaults; payload is not reset
module daylight_led_schedule_curve
  import dlsc_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        time_valid_i,
  input  logic [16:0] second_of_day_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  brightness_o,
  output logic [23:0] color_rgb_o
);

  localparam int unsigned NST     = 5;
  localparam int unsigned ST_CLS  = 0;
  localparam int unsigned ST_SEG  = 1;
  localparam int unsigned ST_DIV  = 2;
  localparam int unsigned ST_PROD = 3;
  localparam int unsigned ST_OUT  = 4;
  localparam int unsigned PROD_W  = SEC_W + DIV60_W;

  // configuration registers
  logic [7:0]  night_level_q, peak_level_q, evening_level_q;
  logic [23:0] morning_rgb_q, day_rgb_q, evening_rgb_q, night_rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      night_level_q   <= 8'd10;
      peak_level_q    <= 8'd255;
      evening_level_q <= 8'd140;
      morning_rgb_q   <= 24'hFFD7AA;
      day_rgb_q       <= 24'hFFAF5A;
      evening_rgb_q   <= 24'hFF550C;
      night_rgb_q     <= 24'hFF3205;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NIGHT_LEVEL:   night_level_q   <= cfg_data_i[7:0];
        CFG_PEAK_LEVEL:    peak_level_q    <= cfg_data_i[7:0];
        CFG_EVENING_LEVEL: evening_level_q <= cfg_data_i[7:0];
        CFG_MORNING_RGB:   morning_rgb_q   <= cfg_data_i;
        CFG_DAY_RGB:       day_rgb_q       <= cfg_data_i;
        CFG_EVENING_RGB:   evening_rgb_q   <= cfg_data_i;
        CFG_NIGHT_RGB:     night_rgb_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits and the ready chain, back to front
  logic [NST-1:0] v_q;
  logic [NST:0]   adv;

  assign adv[NST] = out_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[ST_OUT];

  // stage 0: classify the time and take the minute count by reciprocal multiply
  seg_e                cls_d, c0_seg_q;
  logic [SEC_W-1:0]    c0_s_q;
  logic [MIN_W-1:0]    c0_m_q;
  logic [PROD_W-1:0]   m_prod;

  always_comb begin
    priority if (!time_valid_i) begin
      cls_d = SEG_FALLBACK;
    end else if (second_of_day_i >= SEC_05 && second_of_day_i < SEC_08) begin
      cls_d = SEG_RISE;
    end else if (second_of_day_i >= SEC_08 && second_of_day_i < SEC_16) begin
      cls_d = SEG_DAY;
    end else if (second_of_day_i >= SEC_16 && second_of_day_i < SEC_21) begin
      cls_d = SEG_FADE;
    end else if (second_of_day_i >= SEC_21 && second_of_day_i < SEC_22) begin
      cls_d = SEG_DUSK;
    end else begin
      // includes values past the end of the day
      cls_d = SEG_NIGHT;
    end
  end

  assign m_prod = PROD_W'(second_of_day_i) * PROD_W'(DIV60_MUL);

  always_ff @(posedge clk_i) begin
    if (adv[ST_CLS]) begin
      c0_seg_q <= cls_d;
      c0_s_q   <= second_of_day_i;
      c0_m_q   <= m_prod[DIV60_SHIFT +: MIN_W];
    end
  end

  // stage 1: elapsed time in the segment; night splits into drift and hold
  seg_e              seg1_d, c1_seg_q;
  logic [ELAP_W-1:0] e1_d, c1_e_q;
  logic [MIN_W-1:0]  nm;

  assign nm = (c0_m_q >= MIN_22) ? (c0_m_q - MIN_22) : (c0_m_q + MIN_WRAP);

  always_comb begin
    seg1_d = c0_seg_q;
    e1_d   = '0;
    unique case (c0_seg_q)
      SEG_RISE: e1_d = ELAP_W'(c0_s_q - SEC_05);
      SEG_FADE: e1_d = ELAP_W'(c0_s_q - SEC_16);
      SEG_DUSK: e1_d = ELAP_W'(c0_s_q - SEC_21);
      SEG_NIGHT: begin
        if (nm < NIGHT_SPAN_MIN) begin
          e1_d = ELAP_W'(nm);
        end else begin
          seg1_d = SEG_HOLD;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_SEG]) begin
      c1_seg_q <= seg1_d;
      c1_e_q   <= e1_d;
    end
  end

  // stage 2: fraction elapsed * 2^F / length by reciprocal multiply
  localparam int unsigned RCP_W = FRACTION_BITS + RCP_HEAD_W;
  localparam int unsigned QP_W  = ELAP_W + RCP_W;
  localparam logic [63:0] RCP_ONE = 64'd1;
  localparam logic [RCP_W-1:0] RCP_RISE = RCP_W'(
    ((RCP_ONE << (FRACTION_BITS + RCP_SH_RISE)) + 64'(LEN_RISE) - 64'd1) / 64'(LEN_RISE));
  localparam logic [RCP_W-1:0] RCP_FADE = RCP_W'(
    ((RCP_ONE << (FRACTION_BITS + RCP_SH_FADE)) + 64'(LEN_FADE) - 64'd1) / 64'(LEN_FADE));
  localparam logic [RCP_W-1:0] RCP_DUSK = RCP_W'(
    ((RCP_ONE << (FRACTION_BITS + RCP_SH_DUSK)) + 64'(LEN_DUSK) - 64'd1) / 64'(LEN_DUSK));
  localparam logic [RCP_W-1:0] RCP_NIGHT = RCP_W'(
    ((RCP_ONE << (FRACTION_BITS + RCP_SH_NIGHT)) + 64'(LEN_NIGHT) - 64'd1) / 64'(LEN_NIGHT));

  logic [RCP_W-1:0]         rcp;
  logic [QP_W-1:0]          q_prod;
  logic [FRACTION_BITS-1:0] t2_d;

  always_comb begin
    unique case (c1_seg_q)
      SEG_RISE: rcp = RCP_RISE;
      SEG_FADE: rcp = RCP_FADE;
      SEG_DUSK: rcp = RCP_DUSK;
      default:  rcp = RCP_NIGHT;
    endcase
  end

  // constant spans carry zero elapsed time, so their fraction comes out zero
  assign q_prod = QP_W'(c1_e_q) * QP_W'(rcp);

  always_comb begin
    unique case (c1_seg_q)
      SEG_RISE: t2_d = q_prod[RCP_SH_RISE +: FRACTION_BITS];
      SEG_FADE: t2_d = q_prod[RCP_SH_FADE +: FRACTION_BITS];
      SEG_DUSK: t2_d = q_prod[RCP_SH_DUSK +: FRACTION_BITS];
      default:  t2_d = q_prod[RCP_SH_NIGHT +: FRACTION_BITS];
    endcase
  end

  seg_e                     c2_seg_q;
  logic [FRACTION_BITS-1:0] c2_t_q;

  always_ff @(posedge clk_i) begin
    if (adv[ST_DIV]) begin
      c2_seg_q <= c1_seg_q;
      c2_t_q   <= t2_d;
    end
  end

  logic [FRACTION_BITS-1:0] frac_t;
  seg_e                     seg_t;

  assign frac_t = c2_t_q;
  assign seg_t  = c2_seg_q;

  // endpoint pick; constant spans use the same value at both ends
  logic [7:0]  lvl_a, lvl_b;
  logic [23:0] rgb_a, rgb_b;

  always_comb begin
    unique case (seg_t)
      SEG_RISE: begin
        lvl_a = night_level_q;   lvl_b = peak_level_q;
        rgb_a = morning_rgb_q;   rgb_b = day_rgb_q;
      end
      SEG_DAY: begin
        lvl_a = peak_level_q;    lvl_b = peak_level_q;
        rgb_a = day_rgb_q;       rgb_b = day_rgb_q;
      end
      SEG_FADE: begin
        lvl_a = peak_level_q;    lvl_b = evening_level_q;
        rgb_a = day_rgb_q;       rgb_b = evening_rgb_q;
      end
      SEG_DUSK: begin
        lvl_a = evening_level_q; lvl_b = night_level_q;
        rgb_a = evening_rgb_q;   rgb_b = night_rgb_q;
      end
      SEG_NIGHT: begin
        lvl_a = night_level_q;   lvl_b = night_level_q;
        rgb_a = night_rgb_q;     rgb_b = morning_rgb_q;
      end
      SEG_HOLD: begin
        lvl_a = night_level_q;   lvl_b = night_level_q;
        rgb_a = morning_rgb_q;   rgb_b = morning_rgb_q;
      end
      default: begin
        // time not valid
        lvl_a = FALLBACK_LEVEL;  lvl_b = FALLBACK_LEVEL;
        rgb_a = day_rgb_q;       rgb_b = day_rgb_q;
      end
    endcase
  end

  // stages 3 and 4: multiply and round, four lanes
  lane_en_t lane_en;
  assign lane_en.prod = adv[ST_PROD];
  assign lane_en.out  = adv[ST_OUT];

  dlsc_blend8 #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_level (
    .clk_i (clk_i),
    .en_i  (lane_en),
    .a_i   (lvl_a),
    .b_i   (lvl_b),
    .t_i   (frac_t),
    .y_o   (brightness_o)
  );

  for (genvar c = 0; c < 3; c++) begin : g_rgb
    dlsc_blend8 #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_chan (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .a_i   (rgb_a[8*c +: 8]),
      .b_i   (rgb_b[8*c +: 8]),
      .t_i   (frac_t),
      .y_o   (color_rgb_o[8*c +: 8])
    );
  end

  // segment tag follows the lanes for checking
  seg_e p_seg_q, o_seg_q;

  always_ff @(posedge clk_i) begin
    if (adv[ST_PROD]) begin
      p_seg_q <= seg_t;
    end
    if (adv[ST_OUT]) begin
      o_seg_q <= p_seg_q;
    end
  end

  logic [ELAP_W-1:0] e_len;
  assign e_len = seg_len(c1_seg_q);

  a_fallback_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_OUT] && o_seg_q == SEG_FALLBACK) |-> brightness_o == FALLBACK_LEVEL)
    else $error("fallback transfer without fallback brightness");

  a_const_frac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_DIV] && (seg_t == SEG_DAY || seg_t == SEG_FALLBACK || seg_t == SEG_HOLD))
    |-> frac_t == '0)
    else $error("constant span left the fraction stage with a nonzero fraction");

  a_elapsed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_SEG] |-> c1_e_q < e_len)
    else $error("elapsed time not below the segment length");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v_q[ST_CLS] && v_q[ST_OUT] && !out_ready_i))
    else $error("input held off while the pipeline has room");

endmodule

// ===== verif/tb_daylight_led_schedule_curve.sv =====
// tb_daylight_led_schedule_curve: self-checking bench for the daylight schedule curve
// needs dlsc_pkg (register index enum) and daylight_led_schedule_curve from rtl
// a scoreboard class predicts brightness and color per time transfer; plain tasks drive the ports
module tb_daylight_led_schedule_curve;
  import dlsc_pkg::*;

  localparam int unsigned FB          = 16;      // fraction bits of the blend
  localparam int unsigned CYCLE_LIMIT = 200000;  // watchdog, far above a slow correct run
  localparam int unsigned HOLD_CYCLES = 200;     // long output hold, well past pipeline depth
  localparam int unsigned DRAIN_WAIT  = 16;      // well past the block latency
  localparam int unsigned N_PHASES    = 6;
  localparam int unsigned N_RANDOM    = 70;      // random times per register setting

  // schedule corners in seconds since midnight
  localparam int unsigned T_0500 = 18000;
  localparam int unsigned T_0800 = 28800;
  localparam int unsigned T_1600 = 57600;
  localparam int unsigned T_2100 = 75600;
  localparam int unsigned T_2200 = 79200;
  localparam int unsigned T_2400 = 86400;
  localparam int unsigned M_2200 = 1320;         // 22:00 in minutes
  localparam int unsigned M_WRAP = 120;          // minutes from 22:00 to midnight
  localparam int unsigned M_DRIFT = 360;         // night color drift span in minutes
  localparam logic [7:0]  NO_CLOCK_LEVEL = 8'd200;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        time_valid_i;
  logic [16:0] second_of_day_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  brightness_o;
  logic [23:0] color_rgb_o;

  typedef struct {
    logic        tv;
    logic [16:0] sec;
    logic [7:0]  level;
    logic [23:0] rgb;
  } curve_point_t;

  // predicts the curve from its own register copy and checks results in order
  class curve_scoreboard;
    logic [7:0]   night_lvl, peak_lvl, eve_lvl;
    logic [23:0]  morn_rgb, day_rgb, eve_rgb, night_rgb;
    curve_point_t expected_points[$];
    int unsigned  mismatches;
    int unsigned  matched;

    function new();
      night_lvl  = 8'd10;
      peak_lvl   = 8'd255;
      eve_lvl    = 8'd140;
      morn_rgb   = 24'hFFD7AA;
      day_rgb    = 24'hFFAF5A;
      eve_rgb    = 24'hFF550C;
      night_rgb  = 24'hFF3205;
      mismatches = 0;
      matched    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [23:0] data);
      case (idx)
        CFG_NIGHT_LEVEL:   night_lvl = data[7:0];
        CFG_PEAK_LEVEL:    peak_lvl  = data[7:0];
        CFG_EVENING_LEVEL: eve_lvl   = data[7:0];
        CFG_MORNING_RGB:   morn_rgb  = data;
        CFG_DAY_RGB:       day_rgb   = data;
        CFG_EVENING_RGB:   eve_rgb   = data;
        CFG_NIGHT_RGB:     night_rgb = data;
        default: ;
      endcase
    endfunction

    // rounded-half-up blend, clamped to a byte
    function logic [7:0] mix8(logic [7:0] a, logic [7:0] b, longint t);
      longint acc;
      acc = (longint'(a) << FB) + (longint'(b) - longint'(a)) * t + (longint'(1) << (FB - 1));
      if (acc < 0) acc = 0;
      acc = acc >>> FB;
      return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    function logic [23:0] mix_rgb(logic [23:0] a, logic [23:0] b, longint t);
      return {mix8(a[23:16], b[23:16], t), mix8(a[15:8], b[15:8], t), mix8(a[7:0], b[7:0], t)};
    endfunction

    function longint frac(longint elapsed, longint span);
      return (elapsed << FB) / span;
    endfunction

    function curve_point_t predict_point(logic tv, logic [16:0] sec);
      curve_point_t p;
      int unsigned  s;
      int unsigned  m;
      int unsigned  nm;
      longint       t;
      s = sec;
      p.tv = tv;
      p.sec = sec;
      if (!tv) begin
        // no clock: fixed fallback level and the day color
        p.level = NO_CLOCK_LEVEL;
        p.rgb   = day_rgb;
      end else if (s >= T_0500 && s < T_0800) begin
        t = frac(s - T_0500, T_0800 - T_0500);
        p.level = mix8(night_lvl, peak_lvl, t);
        p.rgb   = mix_rgb(morn_rgb, day_rgb, t);
      end else if (s >= T_0800 && s < T_1600) begin
        p.level = peak_lvl;
        p.rgb   = day_rgb;
      end else if (s >= T_1600 && s < T_2100) begin
        t = frac(s - T_1600, T_2100 - T_1600);
        p.level = mix8(peak_lvl, eve_lvl, t);
        p.rgb   = mix_rgb(day_rgb, eve_rgb, t);
      end else if (s >= T_2100 && s < T_2200) begin
        t = frac(s - T_2100, T_2200 - T_2100);
        p.level = mix8(eve_lvl, night_lvl, t);
        p.rgb   = mix_rgb(eve_rgb, night_rgb, t);
      end else begin
        // night span, also any value past midnight of the 17-bit range
        m  = s / 60;
        nm = (m >= M_2200) ? (m - M_2200) : (m + M_WRAP);
        p.level = night_lvl;
        p.rgb   = (nm < M_DRIFT) ? mix_rgb(night_rgb, morn_rgb, frac(nm, M_DRIFT)) : morn_rgb;
      end
      return p;
    endfunction

    function void note_time(logic tv, logic [16:0] sec);
      expected_points.push_back(predict_point(tv, sec));
    endfunction

    function void check_point(logic [7:0] level, logic [23:0] rgb);
      curve_point_t want;
      if (expected_points.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result transfer: brightness %0d color %06h", level, rgb);
        mismatches++;
        return;
      end
      want = expected_points.pop_front();
      if (level !== want.level || rgb !== want.rgb) begin
        if (mismatches < 10)
          $display("mismatch at valid=%0b sec=%0d: brightness exp %0d got %0d, color exp %06h got %06h",
                   want.tv, want.sec, want.level, level, want.rgb, rgb);
        mismatches++;
      end else begin
        matched++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_points.size();
    endfunction
  endclass

  curve_scoreboard curve_sb;
  bit              tx_gap_en;     // sender idles in bursts
  bit              rx_stall_en;   // receiver stalls in bursts
  bit              hold_off_req;  // set by the stimulus, cleared by the receiver
  int unsigned     cycle_count;
  int unsigned     holds_done;

  daylight_led_schedule_curve dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .time_valid_i   (time_valid_i),
    .second_of_day_i(second_of_day_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .brightness_o   (brightness_o),
    .color_rgb_o    (color_rgb_o)
  );

  // 10 time unit clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on total run length
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // one register write per cycle; the caller drops the write enable afterwards
  task automatic write_reg(cfg_idx_e idx, logic [23:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    curve_sb.set_reg(idx, data);
  endtask

  // full register set; level writes carry whatever upper bits the caller gives
  task automatic program_curve(logic [23:0] night_l, logic [23:0] peak_l, logic [23:0] eve_l,
                               logic [23:0] morn_c, logic [23:0] day_c, logic [23:0] eve_c,
                               logic [23:0] night_c);
    write_reg(CFG_NIGHT_LEVEL, night_l);
    write_reg(CFG_PEAK_LEVEL, peak_l);
    write_reg(CFG_EVENING_LEVEL, eve_l);
    write_reg(CFG_MORNING_RGB, morn_c);
    write_reg(CFG_DAY_RGB, day_c);
    write_reg(CFG_EVENING_RGB, eve_c);
    write_reg(CFG_NIGHT_RGB, night_c);
    cfg_we_i <= 1'b0;
  endtask

  // offer one time transfer and hold it until accepted; maybe idle afterwards
  task automatic send_time(logic tv, logic [16:0] sec);
    in_valid_i      <= 1'b1;
    time_valid_i    <= tv;
    second_of_day_i <= sec;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    curve_sb.note_time(tv, sec);
    if (tx_gap_en && $urandom_range(0, 4) == 0) begin
      // idle burst with junk on the payload
      in_valid_i      <= 1'b0;
      time_valid_i    <= 1'($urandom);
      second_of_day_i <= 17'($urandom);
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // block until every predicted point has come back
  task automatic wait_drained();
    while (curve_sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // random time, weighted by segment so every part of the curve gets traffic
  task automatic pick_time(output logic tv, output logic [16:0] sec);
    tv = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 7))
      0: sec = 17'($urandom_range(T_0500, T_0800 - 1));
      1: sec = 17'($urandom_range(T_0800, T_1600 - 1));
      2: sec = 17'($urandom_range(T_1600, T_2100 - 1));
      3: sec = 17'($urandom_range(T_2100, T_2200 - 1));
      4: sec = 17'($urandom_range(0, T_0500 - 1));
      5: sec = 17'($urandom_range(T_2200, T_2400 - 1));
      6: sec = 17'($urandom_range(T_2400, 131071));
      default: begin
        // any 17-bit pattern, any flag
        tv  = 1'($urandom);
        sec = 17'($urandom);
      end
    endcase
  endtask

  // result side: checks each transfer, stalls in bursts, and honors a long hold
  initial begin : result_sink
    int unsigned n;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) curve_sb.check_point(brightness_o, color_rgb_o);
      if (hold_off_req) begin
        // long hold so the pipeline fills and backs up into the input
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
        holds_done++;
      end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    // schedule corners, wrap points and the top of the 17-bit range
    static int unsigned corner_secs [20] = '{0, 14399, 14400, 17999, 18000, 18001, 28799,
                                             28800, 57599, 57600, 75599, 75600, 79199, 79200,
                                             79260, 86399, 86400, 100799, 100800, 131071};
    int unsigned phase;
    int unsigned i;
    bit          calm;
    logic        tv;
    logic [16:0] sec;

    curve_sb     = new();
    tx_gap_en    = 1'b0;
    rx_stall_en  = 1'b0;
    hold_off_req = 1'b0;
    holds_done   = 0;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= CFG_NIGHT_LEVEL;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    time_valid_i    <= 1'b0;
    second_of_day_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (phase = 0; phase < N_PHASES; phase++) begin
      // registers change only with the pipeline empty
      if (phase != 0) begin
        wait_drained();
        case (phase)
          1: program_curve(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
          2: program_curve(24'hFF, 24'hFF, 24'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
          // the morning level ramp runs downhill, the evening ones uphill; channels at opposite extremes
          3: program_curve(24'hFF, 24'h0, 24'h80, 24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF);
          default: program_curve(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                                 24'($urandom), 24'($urandom), 24'($urandom));
        endcase
      end
      calm = (phase == N_PHASES - 1);

      // directed corners under this setting, plus the no-clock fallback
      tx_gap_en   = !calm;
      rx_stall_en = !calm;
      foreach (corner_secs[k]) send_time(1'b1, 17'(corner_secs[k]));
      send_time(1'b0, 17'd0);
      send_time(1'b0, 17'd57600);
      send_time(1'b0, 17'h1FFFF);

      for (i = 0; i < N_RANDOM; i++) begin
        // idling switches on and off in stretches
        if (i % 25 == 0) begin
          tx_gap_en   = !calm && ($urandom_range(0, 2) != 0);
          rx_stall_en = !calm && ($urandom_range(0, 2) != 0);
        end
        if (phase == 2 && i == 10) hold_off_req = 1'b1;
        pick_time(tv, sec);
        send_time(tv, sec);
      end
      in_valid_i <= 1'b0;
    end

    // drain, then a quiet tail to catch stray results
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("checked %0d brightness/color results over %0d register settings",
             curve_sb.matched, N_PHASES);
    $display("covered every segment, the fallback, past-midnight times and %0d long output hold",
             holds_done);
    if (curve_sb.outstanding() != 0)
      $display("%0d expected results never arrived", curve_sb.outstanding());
    if (curve_sb.mismatches == 0 && curve_sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
